// ===== src/c2es_pkg.sv =====
// Shared types and constants for the calendar-to-epoch-seconds pipeline.
// No dependencies. Used by c2es_year_days and calendar_to_epoch_seconds_core.
`timescale 1ns / 1ps
`default_nettype none

package c2es_pkg;

    // First year of the epoch.
    localparam logic [15:0] C_EPOCH_YEAR    = 16'd1970;
    // Leap years in 1 .. 1969: 492 - 19 + 4.
    localparam logic [15:0] C_LEAPS_TO_1969 = 16'd477;
    localparam logic [8:0]  C_DAYS_PER_YEAR = 9'd365;
    localparam logic [6:0]  C_HUNDRED       = 7'd100;
    // Reciprocal of 100 scaled by 2^23; exact for every 16-bit dividend.
    localparam logic [16:0] C_RECIP_100     = 17'd83887;
    localparam int          C_RECIP_SHIFT   = 23;
    localparam logic [16:0] C_SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] C_SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  C_SECS_PER_MIN  = 6'd60;
    localparam logic [7:0]  C_MONTH_FEB     = 8'd2;

    // Year-dependent parts of the day count, handed from the year unit.
    typedef struct packed {
        logic        leap;       // the year itself is a leap year
        logic [24:0] yoff_days;  // (year - 1970) * 365
        logic [15:0] leaps;      // leap days between 1970 and the year
    } t_year_info;

    // Days before the first of each month; other month numbers use January.
    function automatic logic [8:0] f_days_before_month(input logic [7:0] month);
        logic [8:0] v_days;
        case (month)
            8'd2:    v_days = 9'd31;
            8'd3:    v_days = 9'd59;
            8'd4:    v_days = 9'd90;
            8'd5:    v_days = 9'd120;
            8'd6:    v_days = 9'd151;
            8'd7:    v_days = 9'd181;
            8'd8:    v_days = 9'd212;
            8'd9:    v_days = 9'd243;
            8'd10:   v_days = 9'd273;
            8'd11:   v_days = 9'd304;
            8'd12:   v_days = 9'd334;
            default: v_days = 9'd0;
        endcase
        return v_days;
    endfunction

endpackage

`default_nettype wire

// ===== src/c2es_year_days.sv =====
// Two-stage year unit: splits the year by 100 with a reciprocal multiply and
// derives the leap flag, the leap-day count and the whole-year day offset. Uses c2es_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2es_year_days (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [15:0]       i_year,
    output c2es_pkg::t_year_info   o_info
);
    import c2es_pkg::*;

    logic [32:0] w_recip_prod;
    logic [15:0] r_year;
    logic [9:0]  r_q;

    logic [16:0] w_q100;
    logic [16:0] w_rem;
    logic        w_rem_zero;
    logic [9:0]  w_qn;
    logic [15:0] w_n;
    logic [15:0] w_yoff;
    t_year_info  n_info;
    t_year_info  r_info;

    // Stage one: quotient of the year by 100.
    assign w_recip_prod = i_year * C_RECIP_100;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_year <= i_year;
            r_q    <= w_recip_prod[C_RECIP_SHIFT +: 10];
        end
    end

    // Stage two: remainder, leap rule, and the closed-form leap count of year - 1.
    assign w_q100     = r_q * C_HUNDRED;
    assign w_rem      = {1'b0, r_year} - w_q100;
    assign w_rem_zero = (w_rem == 17'd0);
    // (year - 1) / 100 drops by one exactly when the year is a multiple of 100.
    assign w_qn       = r_q - {9'd0, w_rem_zero};
    assign w_n        = r_year - 16'd1;
    assign w_yoff     = r_year - C_EPOCH_YEAR;

    always_comb begin
        n_info.leap      = w_rem_zero ? (r_q[1:0] == 2'b00) : (r_year[1:0] == 2'b00);
        n_info.yoff_days = w_yoff * C_DAYS_PER_YEAR;
        n_info.leaps     = {2'b00, w_n[15:2]} - {6'd0, w_qn} + {8'd0, w_qn[9:2]}
                         - C_LEAPS_TO_1969;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_info <= n_info;
        end
    end

    assign o_info = r_info;

endmodule

`default_nettype wire

// ===== src/calendar_to_epoch_seconds_core.sv =====
// Throughput: one transaction per cycle; the five-stage pipeline stalls as a
// whole only while its output register holds a result that is not taken.
// Reset: synchronous, active low; clears the stage valid bits only.
// Depends on c2es_pkg and c2es_year_days.
`timescale 1ns / 1ps
`default_nettype none

module calendar_to_epoch_seconds_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_year,
    input  wire logic [7:0]  i_month,
    input  wire logic [7:0]  i_day,
    input  wire logic [7:0]  i_hour,
    input  wire logic [7:0]  i_minute,
    input  wire logic [7:0]  i_second,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [40:0]      o_epoch_seconds
);
    import c2es_pkg::*;

    logic        w_adv;
    logic [5:1]  r_vld;
    logic [5:1]  n_vld;

    logic        r1_ok, r2_ok, r3_ok, r4_ok;
    logic        r1_mgt2, r2_mgt2;
    logic [8:0]  r1_dbm, r2_dbm;
    logic [7:0]  r1_dayadj, r2_dayadj;
    logic [19:0] n1_hms, r1_hms, r2_hms, r3_hms, r4_hms;
    logic [24:0] n3_days, r3_days;
    logic [41:0] w_day_prod;
    logic [40:0] r4_secs;
    logic [40:0] n5_out, r5_out;
    t_year_info  w_info;

    // The whole pipeline moves when the output register is empty or being drained.
    assign w_adv   = !r_vld[5] || i_ready;
    assign o_ready = w_adv;
    assign n_vld   = {r_vld[4:1], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    // Year decomposition, stages one and two.
    c2es_year_days u_year_days (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_year (i_year),
        .o_info (w_info)
    );

    // Stage one: month offset, day adjustment and time-of-day seconds.
    assign n1_hms = i_hour * C_SECS_PER_HOUR + i_minute * C_SECS_PER_MIN
                  + {12'd0, i_second};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ok     <= (i_year >= C_EPOCH_YEAR);
            r1_mgt2   <= (i_month > C_MONTH_FEB);
            r1_dbm    <= f_days_before_month(i_month);
            r1_dayadj <= (i_day == 8'd0) ? 8'd0 : i_day - 8'd1;
            r1_hms    <= n1_hms;
        end
    end

    // Stage two: side data waits for the year unit.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_ok     <= r1_ok;
            r2_mgt2   <= r1_mgt2;
            r2_dbm    <= r1_dbm;
            r2_dayadj <= r1_dayadj;
            r2_hms    <= r1_hms;
        end
    end

    // Stage three: total day count.
    assign n3_days = w_info.yoff_days + {9'd0, w_info.leaps} + {16'd0, r2_dbm}
                   + {24'd0, (r2_mgt2 && w_info.leap)} + {17'd0, r2_dayadj};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_days <= n3_days;
            r3_ok   <= r2_ok;
            r3_hms  <= r2_hms;
        end
    end

    // Stage four: days to seconds.
    assign w_day_prod = r3_days * C_SECS_PER_DAY;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_secs <= w_day_prod[40:0];
            r4_ok   <= r3_ok;
            r4_hms  <= r3_hms;
        end
    end

    // Stage five: add the time of day; years before the epoch give zero.
    assign n5_out = r4_ok ? (r4_secs + {21'd0, r4_hms}) : '0;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_out <= n5_out;
        end
    end

    assign o_valid         = r_vld[5];
    assign o_epoch_seconds = r5_out;

    // A held output freezes every stage's valid bit.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    // An accepted input transaction occupies stage one on the next cycle.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[1])
        else $error("accepted transaction did not enter stage one");

    // A transaction in stage four reaches the output register when the pipe moves.
    a_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[4]) |=> o_valid)
        else $error("transaction lost between stage four and the output");

endmodule

`default_nettype wire

// ===== test/calendar_to_epoch_seconds_core_test.sv =====
// Self-checking testbench for calendar_to_epoch_seconds_core: directed dates,
// back-pressure and random dates, predicted in the bench and compared in order.
// Depends only on the RTL of calendar_to_epoch_seconds_core, c2es_year_days and c2es_pkg.
`timescale 1ns / 1ps

module calendar_to_epoch_seconds_core_test;

    localparam int unsigned EPOCH_YEAR   = 1970;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          DRAIN_CYCLES = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_year;
    logic [7:0]  i_month;
    logic [7:0]  i_day;
    logic [7:0]  i_hour;
    logic [7:0]  i_minute;
    logic [7:0]  i_second;
    logic        o_valid;
    logic        i_ready;
    logic [40:0] o_epoch_seconds;

    // Expected epoch seconds, oldest first.
    logic [40:0] expected_seconds_q[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold_cycles;
    int          quiet_cycles;

    calendar_to_epoch_seconds_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_year          (i_year),
        .i_month         (i_month),
        .i_day           (i_day),
        .i_hour          (i_hour),
        .i_minute        (i_minute),
        .i_second        (i_second),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_epoch_seconds (o_epoch_seconds)
    );

    // Free-running 10 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Leap years in 1 .. n under the Gregorian rule.
    function automatic longint unsigned leap_years_through(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // Days before the first of the month; month numbers outside 1..12 count as January.
    function automatic longint unsigned days_before_month(input logic [7:0] month);
        case (month)
            8'd2:    return 31;
            8'd3:    return 59;
            8'd4:    return 90;
            8'd5:    return 120;
            8'd6:    return 151;
            8'd7:    return 181;
            8'd8:    return 212;
            8'd9:    return 243;
            8'd10:   return 273;
            8'd11:   return 304;
            8'd12:   return 334;
            default: return 0;
        endcase
    endfunction

    // Seconds since the epoch for one broken-down date and time.
    function automatic logic [40:0] epoch_seconds_of(input logic [15:0] year,
                                                     input logic [7:0]  month,
                                                     input logic [7:0]  day,
                                                     input logic [7:0]  hour,
                                                     input logic [7:0]  minute,
                                                     input logic [7:0]  second);
        int unsigned     y;
        logic            leap_year;
        longint unsigned days;
        longint unsigned secs;
        y = int'(year);
        if (y < EPOCH_YEAR) begin
            return '0;
        end
        leap_year = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        days = longint'(y - EPOCH_YEAR) * 365
             + leap_years_through(y - 1) - leap_years_through(EPOCH_YEAR - 1);
        days += days_before_month(month);
        // The raw month number decides the leap day, even when it is out of range.
        if (month > 8'd2 && leap_year) begin
            days += 1;
        end
        if (day != 8'd0) begin
            days += longint'(day) - 1;
        end
        secs = days * 86400 + longint'(hour) * 3600 + longint'(minute) * 60
             + longint'(second);
        return secs[40:0];
    endfunction

    // Offers one date and returns right after the edge at which it is accepted.
    task automatic send_date(input logic [15:0] year, input logic [7:0] month,
                             input logic [7:0] day, input logic [7:0] hour,
                             input logic [7:0] minute, input logic [7:0] second);
        // Each cycle the sender idles with the given percentage.
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_year   <= year;
        i_month  <= month;
        i_day    <= day;
        i_hour   <= hour;
        i_minute <= minute;
        i_second <= second;
        // Handshake signals only change at rising edges, so the falling edge is a safe sample.
        do begin
            @(negedge i_clk);
        end while (o_ready !== 1'b1);
        @(posedge i_clk);
        expected_seconds_q.push_back(epoch_seconds_of(year, month, day, hour, minute, second));
    endtask

    // The epoch itself, the year before it and day zero.
    task automatic test_epoch_boundary();
        send_date(16'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
        send_date(16'd1969, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59);
        send_date(16'd1969, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_date(16'd1970, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
        send_date(16'd1970, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1);
    endtask

    // Every-fourth, century and four-century leap rules.
    task automatic test_leap_rules();
        send_date(16'd2000, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0);
        send_date(16'd2100, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0);
        send_date(16'd2024, 8'd2, 8'd29, 8'd12, 8'd30, 8'd15);
        send_date(16'd2024, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0);
        send_date(16'd2023, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0);
    endtask

    // Month numbers outside 1..12, with and without a leap year.
    task automatic test_month_out_of_range();
        send_date(16'd2024, 8'd0, 8'd10, 8'd1, 8'd2, 8'd3);
        send_date(16'd2024, 8'd13, 8'd10, 8'd1, 8'd2, 8'd3);
        send_date(16'd2024, 8'd255, 8'd10, 8'd1, 8'd2, 8'd3);
        send_date(16'd2023, 8'd13, 8'd10, 8'd1, 8'd2, 8'd3);
    endtask

    // Largest field values and unchecked time of day.
    task automatic test_field_extremes();
        send_date(16'd65535, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_date(16'd65535, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59);
        send_date(16'd1970, 8'd1, 8'd1, 8'd255, 8'd255, 8'd255);
        send_date(16'd2038, 8'd1, 8'd19, 8'd3, 8'd14, 8'd7);
    endtask

    // The receiver holds off for a long stretch while dates keep coming, so the
    // pipeline fills and drops its input ready.
    task automatic test_output_backpressure();
        recv_hold_cycles = 300;
        for (int n = 0; n < 40; n++) begin
            send_date(16'($urandom_range(1970, 2100)), 8'($urandom_range(1, 12)),
                      8'($urandom_range(1, 28)), 8'($urandom_range(0, 23)),
                      8'($urandom_range(0, 59)), 8'($urandom_range(0, 59)));
        end
    endtask

    // Mostly plausible dates, mixed with dates near the range limits and raw noise.
    task automatic test_random_dates(input int count);
        int          pick;
        logic [15:0] year;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_date(16'($urandom_range(1960, 2400)), 8'($urandom_range(1, 12)),
                          8'($urandom_range(1, 31)), 8'($urandom_range(0, 23)),
                          8'($urandom_range(0, 59)), 8'($urandom_range(0, 59)));
            end else if (pick < 85) begin
                year = ($urandom_range(1)) ? 16'($urandom_range(1965, 1975))
                                           : 16'(65535 - $urandom_range(0, 3));
                send_date(year, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
            end else begin
                send_date(16'($urandom_range(65535)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)));
            end
        end
    endtask

    // Output acceptance: random stalls, or a counted hold-off when one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (recv_hold_cycles > 0) begin
                i_ready <= 1'b0;
                recv_hold_cycles = recv_hold_cycles - 1;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each output transaction with the oldest expectation.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_seconds_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, o_epoch_seconds);
                error_count++;
            end else begin
                if (o_epoch_seconds !== expected_seconds_q[0]) begin
                    $display("%0t: epoch_seconds mismatch, expected %0d, actual %0d",
                             $time, expected_seconds_q[0], o_epoch_seconds);
                    error_count++;
                end
                void'(expected_seconds_q.pop_front());
            end
        end
    end

    // Watchdog: too many cycles without any transaction on either side ends the run.
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("calendar_to_epoch_seconds_core_test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        error_count      = 0;
        quiet_cycles     = 0;
        recv_hold_cycles = 0;
        send_idle_pct    = 13;
        recv_idle_pct    = 46;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_ready  <= 1'b0;
        i_year   <= '0;
        i_month  <= '0;
        i_day    <= '0;
        i_hour   <= '0;
        i_minute <= '0;
        i_second <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_epoch_boundary();
        test_leap_rules();
        test_month_out_of_range();
        test_field_extremes();

        send_idle_pct = 0;
        test_output_backpressure();

        send_idle_pct = 13;
        recv_idle_pct = 46;
        test_random_dates(500);
        send_idle_pct = 46;
        recv_idle_pct = 13;
        test_random_dates(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_dates(500);

        // Drain the pipeline, then keep watching for stray results.
        i_valid <= 1'b0;
        while (expected_seconds_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_seconds_q.size() == 0) begin
            $display("calendar_to_epoch_seconds_core_test passed");
        end else begin
            $display("calendar_to_epoch_seconds_core_test failed");
        end
        $finish;
    end

endmodule
